// ===== rtl/swkth_pkg.sv =====
// Shared types and constants of the sliding-window rank-order filter.
package swkth_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int VALUE_W    = 32;
   localparam int RANK_W     = 7;
   localparam int CFG_W      = 7;
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int PTR_W      = $clog2(WINDOW_MAX);
   localparam int SEL_W      = (CNT_W > RANK_W) ? CNT_W : RANK_W;
   localparam int GROUP_SIZE = 8;
   localparam int GROUPS     = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int LEN_RESET  = (WINDOW_MAX < 64) ? WINDOW_MAX : 64;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef value_type [WINDOW_MAX-1:0] window_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sample;
      logic [RANK_W-1:0]         rank;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] selected_value;
      logic                      rank_invalid;
   } rsp_type;

   // per-cell control from the window bookkeeping
   typedef struct packed {
      logic load;    // an item is accepted this cycle
      logic del_en;  // window full: drop one copy of the oldest sample
      logic live;    // cell lies below the top slot after compaction
      logic top;     // cell is the top slot after compaction
   } cell_ctrl_type;

endpackage

// ===== rtl/swkth_ring.sv =====
// Sample ring: remembers arrival order so the oldest value is known on eviction.
module swkth_ring (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [swkth_pkg::PTR_W-1:0]    wr_addr,
   input  swkth_pkg::value_type           wr_data,
   input  logic [swkth_pkg::PTR_W-1:0]    rd_addr,
   output swkth_pkg::value_type           rd_data
);
   import swkth_pkg::*;

   value_type mem [WINDOW_MAX];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write-through when the slot being read is written in the same cycle
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/swkth_cell.sv =====
// One slot of the sorted chain: delete-compact and insert in a single step.
module swkth_cell (
   input  logic                     clock,
   input  swkth_pkg::cell_ctrl_type ctrl,
   input  swkth_pkg::value_type     sample,
   input  swkth_pkg::value_type     oldest,
   input  swkth_pkg::value_type     v_up,    // value of the cell above
   input  swkth_pkg::value_type     w_dn,    // compacted value of the cell below
   input  logic                     gtp_dn,  // cell below shifts up
   output swkth_pkg::value_type     v,
   output swkth_pkg::value_type     w,
   output logic                     gtp
);
   import swkth_pkg::*;

   value_type v_ff;
   value_type v_in;
   logic      ge;

   // first cell >= oldest holds the copy to drop; everything from there moves down
   assign ge  = ctrl.del_en && (v_ff >= oldest);
   assign w   = ge ? v_up : v_ff;
   assign gtp = ctrl.live && (ge ? (v_up > sample) : (v_ff > sample));

   always_comb begin
      if (gtp_dn) begin
         v_in = w_dn;
      end else if (gtp || ctrl.top) begin
         v_in = sample;
      end else begin
         v_in = w;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         v_ff <= v_in;
      end
   end

   assign v = v_ff;

endmodule

// ===== rtl/swkth_select.sv =====
// Rank pick over the sorted chain: registered two-level OR tree and output register.
module swkth_select (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  swkth_pkg::window_type          cells,
   input  logic                           sel_valid,
   input  logic [swkth_pkg::RANK_W-1:0]   sel_rank,
   input  logic                           sel_invalid,
   output logic                           rsp_valid,
   output swkth_pkg::rsp_type             rsp_data
);
   import swkth_pkg::*;

   value_type grp_ff [GROUPS];
   value_type grp_in [GROUPS];
   logic      grp_valid_ff;
   logic      grp_inval_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   value_type out_in;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if ((g * GROUP_SIZE + j) < WINDOW_MAX) begin
               if (!sel_invalid &&
                   (SEL_W'(sel_rank) == SEL_W'(g * GROUP_SIZE + j + 1))) begin
                  grp_in[g] = grp_in[g] | cells[g * GROUP_SIZE + j];
               end
            end
         end
      end
   end

   always_comb begin
      out_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         out_in = out_in | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         grp_valid_ff <= sel_valid;
         rsp_valid_ff <= grp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         grp_ff       <= grp_in;
         grp_inval_ff <= sel_invalid;
         rsp_ff.selected_value <= out_in;
         rsp_ff.rank_invalid   <= grp_inval_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/sliding_window_kth_smallest.sv =====
// Top level of the sliding-window rank-order filter.
//
//  channel  | ports                        | direction | moves
//  ---------+------------------------------+-----------+------------------------------
//  request  | req_valid/req_ready/req_data | in        | item: sample, rank
//  response | rsp_valid/rsp_ready/rsp_data | out       | item: selected_value, flag
//  csr      | csr_wr_en/csr_wr_data        | in        | window_length write
//
//  One item per cycle is accepted while the response side keeps up. The sorted
//  cell chain drops the oldest sample and inserts the new one in the accept cycle;
//  the rank pick then runs through two registered OR levels, so a response passes
//  stage A, the group register and the output register after its item is accepted.
//  Reset (synchronous) sets window_length to 64 and empties the window; a csr
//  write also empties it. The first window_length-1 items give no response.
//  A stalled response freezes the whole pipe, and req_ready drops with it.
module sliding_window_kth_smallest (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  swkth_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output swkth_pkg::rsp_type            rsp_data,
   input  logic                          csr_wr_en,
   input  logic [swkth_pkg::CFG_W-1:0]   csr_wr_data
);
   import swkth_pkg::*;

   // window bookkeeping
   logic [CNT_W-1:0]  len_ff,    len_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  top_idx;
   logic              full;
   logic              adv;
   logic              accept;
   logic              has_result;

   // stage A: the item whose window now sits in the chain
   logic              a_valid_ff;
   logic [RANK_W-1:0] a_rank_ff;
   logic              a_inval_ff;

   value_type         oldest;
   window_type        cell_v;
   window_type        cell_w;
   logic [WINDOW_MAX-1:0] cell_gtp;
   cell_ctrl_type     ctrl [WINDOW_MAX];

   assign adv        = !rsp_valid || rsp_ready;
   assign req_ready  = adv;
   assign accept     = req_valid && adv;
   assign full       = (count_ff == len_ff);
   assign has_result = full || ((count_ff + CNT_W'(1)) == len_ff);
   // highest occupied slot once the oldest copy is squeezed out
   assign top_idx    = full ? (len_ff - CNT_W'(1)) : count_ff;

   // window length: 0 acts as 1, anything beyond capacity is clamped
   always_comb begin
      len_in = len_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            len_in = CNT_W'(1);
         end else if (int'(csr_wr_data) > WINDOW_MAX) begin
            len_in = CNT_W'(WINDOW_MAX);
         end else begin
            len_in = CNT_W'(csr_wr_data);
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      if (csr_wr_en) begin
         count_in  = '0;
         wr_ptr_in = '0;
      end else if (accept) begin
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (wr_ptr_ff == PTR_W'(len_ff - CNT_W'(1))) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= CNT_W'(LEN_RESET);
         count_ff   <= '0;
         wr_ptr_ff  <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         len_ff    <= len_in;
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         if (adv) begin
            a_valid_ff <= accept && has_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_rank_ff  <= req_data.rank;
         a_inval_ff <= (req_data.rank == '0) ||
                       (SEL_W'(req_data.rank) > SEL_W'(len_ff));
      end
   end

   // ring slot at wr_ptr holds the sample that leaves when the window is full
   swkth_ring u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_data.sample),
      .rd_addr (wr_ptr_in),
      .rd_data (oldest)
   );

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      value_type v_up;
      value_type w_dn;
      logic      gtp_dn;

      assign ctrl[i] = '{load:   accept,
                         del_en: full,
                         live:   (top_idx > CNT_W'(i)),
                         top:    (top_idx == CNT_W'(i))};

      if (i == WINDOW_MAX - 1) begin : g_last
         assign v_up = '0;
      end else begin : g_mid
         assign v_up = cell_v[i+1];
      end

      if (i == 0) begin : g_first
         assign w_dn   = '0;
         assign gtp_dn = 1'b0;
      end else begin : g_rest
         assign w_dn   = cell_w[i-1];
         assign gtp_dn = cell_gtp[i-1];
      end

      swkth_cell u_cell (
         .clock  (clock),
         .ctrl   (ctrl[i]),
         .sample (req_data.sample),
         .oldest (oldest),
         .v_up   (v_up),
         .w_dn   (w_dn),
         .gtp_dn (gtp_dn),
         .v      (cell_v[i]),
         .w      (cell_w[i]),
         .gtp    (cell_gtp[i])
      );
   end

   swkth_select u_select (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .cells       (cell_v),
      .sel_valid   (a_valid_ff),
      .sel_rank    (a_rank_ff),
      .sel_invalid (a_inval_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // fill level never passes the window length
   assert property (@(posedge clock) disable iff (reset) count_ff <= len_ff)
      else $error("window fill above window length");

   // ring pointer stays inside the active ring
   assert property (@(posedge clock) disable iff (reset)
                    CNT_W'(wr_ptr_ff) < len_ff)
      else $error("ring pointer outside window");

   // a pick is only pending for an item that was just taken
   assert property (@(posedge clock) disable iff (reset)
                    $rose(a_valid_ff) |-> $past(req_valid && req_ready))
      else $error("rank pick without accepted item");

   // a csr write empties the window
   assert property (@(posedge clock) disable iff (reset)
                    csr_wr_en |=> (count_ff == '0) && (wr_ptr_ff == '0))
      else $error("window not flushed after csr write");

endmodule

// ===== test/sliding_window_kth_smallest_tb.sv =====
// Testbench for the sliding-window rank-order filter: directed and random items, self-checking.
`timescale 1ns / 1ps

module sliding_window_kth_smallest_tb;
   import swkth_pkg::*;

   // run limit in clock cycles, far above the slowest legal run
   localparam int CYCLE_LIMIT = 300000;
   // settle time before a csr write: covers the three-stage response pipe
   localparam int SETTLE_CYCLES = 8;

   localparam value_type VAL_MIN = 32'sh8000_0000;
   localparam value_type VAL_MAX = 32'sh7FFF_FFFF;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CFG_W-1:0]     csr_wr_data = '0;

   // idle rates in percent, changed between phases
   int unsigned          send_idle_pct = 0;
   int unsigned          recv_idle_pct = 0;

   int unsigned          cycle_cnt = 0;
   int unsigned          err_cnt = 0;
   int unsigned          sent_cnt = 0;

   // local copy of the filter state
   value_type            win_store [WINDOW_MAX];
   logic [CFG_W-1:0]     len_reg = CFG_W'(64);
   int unsigned          held_cnt = 0;
   int unsigned          head_slot = 0;

   // expected responses, oldest first
   rsp_type              expected_rsp [$];

   sliding_window_kth_smallest DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("sliding_window_kth_smallest_tb: done, errors");
         $finish;
      end
   end

   // response-side backpressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // register value as the filter uses it: 0 acts as 1, above max clamps
   function automatic int unsigned window_size();
      if (len_reg == 0)
         return 1;
      if (len_reg > WINDOW_MAX)
         return WINDOW_MAX;
      return len_reg;
   endfunction

   // r-th smallest of the first len slots; duplicates count separately
   function automatic value_type kth_of_window(int unsigned len, int unsigned r);
      int unsigned lt;
      int unsigned le;
      for (int i = 0; i < len; i++) begin
         lt = 0;
         le = 0;
         for (int j = 0; j < len; j++) begin
            if (win_store[j] < win_store[i])
               lt++;
            if (win_store[j] <= win_store[i])
               le++;
         end
         if (lt < r && r <= le)
            return win_store[i];
      end
      return '0;
   endfunction

   // advance the local window by one accepted item, queue its response if any
   task automatic predict_item(input req_type item);
      int unsigned len;
      int unsigned slot;
      rsp_type     res;
      len = window_size();
      if (head_slot >= len)
         head_slot = 0;
      if (held_cnt >= len)
         held_cnt = len - 1;
      slot = (head_slot + held_cnt) % len;
      win_store[slot] = item.sample;
      if (held_cnt + 1 < len) begin
         // window still filling: no response
         held_cnt++;
      end else begin
         if (item.rank < 1 || item.rank > len) begin
            res.selected_value = '0;
            res.rank_invalid   = 1'b1;
         end else begin
            res.selected_value = kth_of_window(len, item.rank);
            res.rank_invalid   = 1'b0;
         end
         expected_rsp.push_back(res);
         // oldest sample leaves
         head_slot = (head_slot + 1) % len;
         held_cnt  = len - 1;
      end
   endtask

   // ---------------------------------------------------------------------
   // Response checker: every accepted response against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response, got value %0d invalid %0b",
                     $time, rsp_data.selected_value, rsp_data.rank_invalid);
            err_cnt++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.selected_value !== want.selected_value) begin
               $display("%0t: selected_value mismatch, expected %0d, got %0d",
                        $time, want.selected_value, rsp_data.selected_value);
               err_cnt++;
            end
            if (rsp_data.rank_invalid !== want.rank_invalid) begin
               $display("%0t: rank_invalid mismatch, expected %0b, got %0b",
                        $time, want.rank_invalid, rsp_data.rank_invalid);
               err_cnt++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers; all are entered and left at a falling edge
   // ---------------------------------------------------------------------

   // one item through the request handshake, with random idle cycles first;
   // valid stays high into the next call when no idle cycle is drawn
   task automatic send_item(input value_type s, input logic [RANK_W-1:0] r);
      req_type item;
      item.sample = s;
      item.rank   = r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_item(item);
      sent_cnt++;
      @(negedge clock);
   endtask

   // window_length write, only once the pipe has drained
   task automatic write_length(input logic [CFG_W-1:0] v);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(negedge clock);
      // items that give no response may still sit in the pipe
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      // a write flushes the window
      len_reg   = v;
      held_cnt  = 0;
      head_slot = 0;
   endtask

   // mix of extremes, a narrow band for ties, and full-range values
   function automatic value_type rand_sample();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         case ($urandom_range(3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      if (pick < 5)
         return value_type'($signed($urandom_range(16)) - 8);
      return value_type'($urandom);
   endfunction

   // mostly valid ranks, some out of range, some over the whole field
   function automatic logic [RANK_W-1:0] rand_rank(int unsigned len);
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 8)
         return RANK_W'($urandom_range(len, 1));
      if (pick == 8)
         return ($urandom_range(1) == 0) ? RANK_W'(0) : RANK_W'($urandom_range(127, len + 1));
      return RANK_W'($urandom_range(127));
   endfunction

   task automatic send_random_items(input int unsigned n);
      for (int i = 0; i < n; i++)
         send_item(rand_sample(), rand_rank(window_size()));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // length from reset (64): 63 silent items, then one response per item
   task automatic test_reset_length();
      send_random_items(WINDOW_MAX - 1 + 20);
   endtask

   // window of one: every item answers over itself alone
   task automatic test_window_one();
      write_length(CFG_W'(1));
      send_item(VAL_MIN, RANK_W'(1));
      send_item(VAL_MAX, RANK_W'(1));
      send_item('0, RANK_W'(0));      // rank zero
      send_item(-1, RANK_W'(2));      // rank just above the window
      send_item(5, RANK_W'(127));     // largest rank the field holds
   endtask

   // register value zero behaves as a window of one
   task automatic test_length_zero();
      write_length(CFG_W'(0));
      send_item(VAL_MAX, RANK_W'(1));
      send_item(VAL_MIN, RANK_W'(0));
      send_item(3, RANK_W'(1));
   endtask

   // short window: fill gap, ties at both extremes, every rank, invalid ranks
   task automatic test_small_window();
      write_length(CFG_W'(4));
      send_item(VAL_MIN, RANK_W'(1));
      send_item(VAL_MAX, RANK_W'(1));
      send_item(VAL_MIN, RANK_W'(1));
      send_item(VAL_MAX, RANK_W'(1));   // first response
      send_item(7, RANK_W'(2));
      send_item(7, RANK_W'(3));
      send_item(-7, RANK_W'(4));
      send_item('0, RANK_W'(0));
      send_item(1, RANK_W'(5));
      send_item(-1, RANK_W'(127));
   endtask

   // register value above the maximum clamps to 64
   task automatic test_length_max();
      write_length(CFG_W'(127));
      send_random_items(WINDOW_MAX - 1 + 10);
   endtask

   // random phases: random length per phase, random item count, some phases
   // cut short so the flush lands on a partly filled window
   task automatic test_random_phases();
      logic [CFG_W-1:0] raw;
      int unsigned      len;
      int unsigned      n;
      while (sent_cnt < 1700) begin
         // idle pattern by progress: sender light/receiver heavy, swapped, none
         if (sent_cnt < 700) begin
            send_idle_pct = 25;
            recv_idle_pct = 51;
         end else if (sent_cnt < 1200) begin
            send_idle_pct = 51;
            recv_idle_pct = 25;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(9))
            0, 1, 2, 3: raw = CFG_W'($urandom_range(8, 1));
            4, 5:       raw = CFG_W'($urandom_range(32, 9));
            6:          raw = CFG_W'(WINDOW_MAX);
            7:          raw = '0;
            8:          raw = CFG_W'($urandom_range(127, WINDOW_MAX + 1));
            default:    raw = CFG_W'($urandom_range(WINDOW_MAX - 1, 33));
         endcase
         write_length(raw);
         len = window_size();
         if ($urandom_range(99) < 15)
            n = $urandom_range(len - 1, 0);
         else
            n = len - 1 + $urandom_range(60, 5);
         send_random_items(n);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < WINDOW_MAX; i++)
         win_store[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 25;
      recv_idle_pct = 51;
      test_reset_length();
      test_window_one();
      test_length_zero();
      test_small_window();
      test_length_max();
      test_random_phases();

      // drain, then give the pipe time to show any stray response
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (err_cnt == 0)
         $display("sliding_window_kth_smallest_tb: done, clean");
      else
         $display("sliding_window_kth_smallest_tb: done, errors");
      $finish;
   end

endmodule
